// File: rtl/firhp_pkg.sv
// Shared constants, coefficient table and control types for the 27-tap high-pass FIR.
package firhp_pkg;

   localparam int TAPS       = 27;
   localparam int COEF_WIDTH = 16;
   localparam int SAMPLE_W   = 16;
   localparam int PTR_W      = $clog2(TAPS);
   localparam int PROD_W     = SAMPLE_W + COEF_WIDTH;
   // Coefficient magnitudes sum to a little over 2.0, so five guard bits are ample.
   localparam int ACC_W      = PROD_W + 5;
   localparam int FRAC_BITS  = COEF_WIDTH - 1;
   localparam int COEF_SHIFT = 23 - FRAC_BITS;
   localparam int ROUND_BIAS = (1 << COEF_SHIFT) >> 1;
   localparam int TRUNC_BIAS = (1 << FRAC_BITS) - 1;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // Q1.23 coefficients, newest sample first.
   localparam logic signed [23:0] COEF_Q23 [TAPS] = '{
      -24'sd76535,   24'sd283762,  -24'sd280546, -24'sd101182,  24'sd190128,
       24'sd219033, -24'sd109691,  -24'sd384366, -24'sd92806,   24'sd557196,
       24'sd578832, -24'sd689226,  -24'sd2557441, 24'sd4932997, -24'sd2557441,
      -24'sd689226,  24'sd578832,   24'sd557196, -24'sd92806,   -24'sd384366,
      -24'sd109691,  24'sd219033,   24'sd190128, -24'sd101182,  -24'sd280546,
       24'sd283762, -24'sd76535
   };

   // Q1.23 rounded half up to COEF_WIDTH bits.
   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [PTR_W-1:0] idx);
      logic signed [24:0] q;
      logic signed [24:0] t;
      begin
         q = '0;
         if (int'(idx) < TAPS) begin
            q = 25'(COEF_Q23[idx]);
         end
         t = q + 25'(ROUND_BIAS);
         coef_at = COEF_WIDTH'(t >>> COEF_SHIFT);
      end
   endfunction

   typedef struct packed {
      logic             load;    // take item: write sample, point reads at it, clear sum
      logic             mac;     // multiply one tap
      logic             accum;   // add registered product
      logic             finish;  // scale, saturate, load output, advance pointer
      logic [PTR_W-1:0] tap;
   } firhp_cmd_type;

   typedef struct packed {
      logic out_free;
   } firhp_sts_type;

endpackage

// File: rtl/firhp_dp.sv
// Datapath: delay line, multiply-accumulate, scaling and output register.
module firhp_dp import firhp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  firhp_cmd_type              cmd,
   output firhp_sts_type              sts,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [SAMPLE_W-1:0] out_sample,
   output logic                       out_clipped
);

   logic signed [SAMPLE_W-1:0] delay_ff [TAPS];
   logic signed [SAMPLE_W-1:0] delay_in [TAPS];
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic [PTR_W-1:0]           rd_ff, rd_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                       clip_ff, clip_in;
   logic                       valid_ff, valid_in;

   logic signed [ACC_W-1:0]    biased;
   logic signed [ACC_W-1:0]    quot;
   logic                       sat_hi, sat_lo;

   // truncate toward zero: bias negative sums before the arithmetic shift
   always_comb begin
      biased = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(TRUNC_BIAS) : ACC_W'(0));
      quot   = biased >>> FRAC_BITS;
      sat_hi = quot > ACC_W'(SAMPLE_MAX);
      sat_lo = quot < ACC_W'(SAMPLE_MIN);
   end

   always_comb begin
      delay_in = delay_ff;
      wp_in    = wp_ff;
      rd_in    = rd_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      clip_in  = clip_ff;
      valid_in = valid_ff;

      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         delay_in[wp_ff] = sample_in;
         rd_in           = wp_ff;
         acc_in          = '0;
      end
      if (cmd.mac) begin
         prod_in = delay_ff[rd_ff] * coef_at(cmd.tap);
         rd_in   = (rd_ff == '0) ? PTR_W'(TAPS - 1) : rd_ff - 1'b1;
      end
      if (cmd.accum) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         valid_in = 1'b1;
         clip_in  = sat_hi | sat_lo;
         if (sat_hi) begin
            res_in = SAMPLE_W'(SAMPLE_MAX);
         end else if (sat_lo) begin
            res_in = SAMPLE_W'(SAMPLE_MIN);
         end else begin
            res_in = quot[SAMPLE_W-1:0];
         end
         wp_in = (wp_ff == PTR_W'(TAPS - 1)) ? '0 : wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            delay_ff[i] <= '0;
         end
         wp_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         delay_ff <= delay_in;
         wp_ff    <= wp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      clip_ff <= clip_in;
   end

   assign sts.out_free = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign out_sample   = res_ff;
   assign out_clipped  = clip_ff;

endmodule

// File: rtl/firhp_ctrl.sv
// Controller: sequences load, tap-by-tap multiply-accumulate and result hand-off.
module firhp_ctrl import firhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  firhp_sts_type sts,
   output firhp_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] tap_ff, tap_in;
   logic             last_tap;

   assign last_tap = tap_ff == PTR_W'(TAPS - 1);
   assign in_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      cmd        = '0;
      cmd.tap    = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               tap_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac   = 1'b1;
            cmd.accum = tap_ff != '0;
            tap_in    = tap_ff + 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.accum = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == ST_MAC && tap_ff == '0))
      else $error("accepted item did not start at tap zero");

   a_last_tap_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && last_tap) |=> (state_ff == ST_DRAIN))
      else $error("last tap not followed by drain");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("result loaded over an untaken result");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mac |-> (int'(tap_ff) < TAPS))
      else $error("tap index out of range");

endmodule

// File: rtl/fir_highpass_27tap.sv
// Top level of the 27-tap symmetric high-pass FIR filter.
// Sequence: accept, one multiply-accumulate per tap over all 27 taps, drain, then scale into rsp_valid.
// No new item is accepted until the result is handed off; one shared multiplier, one tap a cycle.
// A finished item waits in the output register while the next one is computed; the scale
//   step of that next item stalls until rsp_ready, with req_ready low meanwhile.
// Reset (synchronous, active high) zeroes the delay line, write pointer and control state.
module fir_highpass_27tap import firhp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input item channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   // result item channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_clipped
);

   firhp_cmd_type cmd;
   firhp_sts_type sts;

   // sequencer: idle -> MAC over every tap -> drain -> hand result to output register
   firhp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // delay line in flops, one 16 x 16 multiplier, wide accumulator, saturating scaler
   firhp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .sample_in   (req_sample_in),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_sample  (rsp_sample_out),
      .out_clipped (rsp_clipped)
   );

endmodule
